@@ rtl/rcs_pkg.sv @@
`timescale 1ns / 1ps
// rcs_pkg: shared constants and handshake types for the random command selector.
// No dependencies; used by rcs_scan and random_command_selector.
package rcs_pkg;

    // Default size of the command table.
    localparam int MAX_COMMANDS_DEF = 32;

    // Fixed field widths.
    localparam int COUNT_W    = 6;
    localparam int MODE_W     = 4;
    localparam int RND_W      = 15;
    localparam int BUSY_W     = 32;
    localparam int SEL_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS    = 1'b1;

    // Bit positions inside mode_flags.
    localparam int MODE_SEQ_BIT    = 0;
    localparam int MODE_COVER_BIT  = 1;
    localparam int MODE_NOREP_BIT  = 2;
    localparam int MODE_ONECYC_BIT = 3;

    // Operation codes.
    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Sequencer to scan unit.
    typedef struct packed {
        logic start;   // load mask/rank and begin a pass
        logic find;    // 1: stop at the rank-th free index, 0: count free indices
    } scan_req_t;

    // Scan unit to sequencer.
    typedef struct packed {
        logic done;    // one-cycle pulse at the end of a pass
        logic hit;     // find pass reached its rank
    } scan_rsp_t;

endpackage

@@ rtl/rcs_scan.sv @@
`timescale 1ns / 1ps
// rcs_scan: bit-serial scan over the exclusion mask, one index per cycle.
// Counts free indices or locates the rank-th free one. Depends on rcs_pkg.
module rcs_scan #(
    parameter int MAX_COMMANDS = rcs_pkg::MAX_COMMANDS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rcs_pkg::scan_req_t                     req,
    input  logic [MAX_COMMANDS-1:0]                mask,
    input  logic [$clog2(MAX_COMMANDS+1)-1:0]      n,
    input  logic [$clog2(MAX_COMMANDS+1)-1:0]      rank,
    output rcs_pkg::scan_rsp_t                     rsp,
    output logic [$clog2(MAX_COMMANDS+1)-1:0]      count,
    output logic [$clog2(MAX_COMMANDS)-1:0]        index
);
    import rcs_pkg::*;

    localparam int CW = $clog2(MAX_COMMANDS + 1);
    localparam int IW = $clog2(MAX_COMMANDS);

    logic [MAX_COMMANDS-1:0] mask_reg, mask_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           rank_reg, rank_next;
    logic [IW-1:0]           pick_reg, pick_next;
    logic                    run_reg, run_next;
    logic                    find_reg, find_next;
    logic                    hit_reg, hit_next;
    logic                    done_reg, done_next;
    logic [CW-1:0]           idx_inc;

    assign idx_inc = idx_reg + 1'b1;

    always_comb
    begin
        mask_next = mask_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        rank_next = rank_reg;
        pick_next = pick_reg;
        run_next  = run_reg;
        find_next = find_reg;
        hit_next  = hit_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            mask_next = mask;
            idx_next  = '0;
            cnt_next  = '0;
            rank_next = rank;
            pick_next = '0;
            run_next  = 1'b1;
            find_next = req.find;
            hit_next  = 1'b0;
        end
        else if (run_reg)
        begin
            mask_next = mask_reg >> 1;
            idx_next  = idx_inc;
            if (idx_inc == n)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            if (!mask_reg[0])
            begin
                if (find_reg)
                begin
                    if (rank_reg == '0)
                    begin
                        hit_next  = 1'b1;
                        pick_next = idx_reg[IW-1:0];
                        run_next  = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rank_next = rank_reg - 1'b1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            idx_reg  <= '0;
            cnt_reg  <= '0;
            rank_reg <= '0;
            pick_reg <= '0;
            run_reg  <= 1'b0;
            find_reg <= 1'b0;
            hit_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            idx_reg  <= idx_next;
            cnt_reg  <= cnt_next;
            rank_reg <= rank_next;
            pick_reg <= pick_next;
            run_reg  <= run_next;
            find_reg <= find_next;
            hit_reg  <= hit_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.hit  = hit_reg;
    assign count    = cnt_reg;
    assign index    = pick_reg;

endmodule

@@ rtl/random_command_selector.sv @@
`timescale 1ns / 1ps
// random_command_selector: top level, sequencer, selection state and ports.
// Depends on rcs_pkg and rcs_scan.
//
// Picks the next command index out of command_count (capped at MAX_COMMANDS).
// A clear-history request, a count of zero and sequential mode answer
// directly: the result is registered at the transfer edge. A random pick runs
// the shared bit-serial scan unit over the exclusion mask, one index per
// cycle: a counting pass (skipped when there is no previous pick), a
// multiply step that scales random_value by the free count, and a find
// pass that locates the chosen free index. If the counting pass finds no
// free index, the pick ends with found low, unless coverall mode without
// the onecyc flag refills its mask and goes on. The request side
// stalls while a pick is in progress and while an unaccepted result holds the
// output register. Configuration writes are always ready and must only be
// issued while the block is idle.
module random_command_selector #(
    parameter int MAX_COMMANDS = rcs_pkg::MAX_COMMANDS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request channel
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              operation,
    input  logic [rcs_pkg::RND_W-1:0]         random_value,
    input  logic [rcs_pkg::BUSY_W-1:0]        busy_mask,
    // result channel
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [rcs_pkg::SEL_W-1:0]         selected_index,
    output logic                              found
);
    import rcs_pkg::*;

    localparam int CW   = $clog2(MAX_COMMANDS + 1);   // counts 0..MAX_COMMANDS
    localparam int IW   = $clog2(MAX_COMMANDS);       // index 0..MAX_COMMANDS-1
    localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT_GO,
        S_COUNT,
        S_MUL,
        S_FIND_GO,
        S_FIND
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_W-1:0]      command_count_reg, command_count_next;
    logic [MODE_W-1:0]       mode_flags_reg, mode_flags_next;
    logic                    last_valid_reg, last_valid_next;
    logic [IW-1:0]           last_index_reg, last_index_next;
    logic [MAX_COMMANDS-1:0] excl_reg, excl_next;
    logic [CW-1:0]           free_reg, free_next;
    logic [CW-1:0]           nth_reg, nth_next;
    logic [RND_W-1:0]        rnd_reg, rnd_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [SEL_W-1:0]        selected_index_reg, selected_index_next;
    logic                    found_reg, found_next;

    // effective count n = min(command_count, MAX_COMMANDS)
    logic [CMPW-1:0]         cnt_ext, max_ext, n_wide;
    logic [CW-1:0]           n_eff;
    logic [MAX_COMMANDS-1:0] in_range;
    logic [MAX_COMMANDS-1:0] busy_in;
    logic [BUSY_W+MAX_COMMANDS-1:0] busy_wide;
    logic [MAX_COMMANDS-1:0] last_bit;
    logic [IW:0]             seq_next;
    logic [IW:0]             n_cmp;
    logic                    refill_keep;
    logic                    last_in_range;
    logic [RND_W+CW-1:0]     product;
    logic [IW+SEL_W-1:0]     pick_wide;
    logic [IW-1:0]           pick;
    logic                    req_xfer;
    logic                    mode_seq, mode_cover, mode_norep, mode_onecyc;

    scan_req_t               scan_req;
    scan_rsp_t               scan_rsp;
    logic [CW-1:0]           scan_count;
    logic [IW-1:0]           scan_index;

    rcs_scan #(
        .MAX_COMMANDS (MAX_COMMANDS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scan_req),
        .mask  (excl_reg),
        .n     (n_eff),
        .rank  (nth_reg),
        .rsp   (scan_rsp),
        .count (scan_count),
        .index (scan_index)
    );

    assign mode_seq    = mode_flags_reg[MODE_SEQ_BIT];
    assign mode_cover  = mode_flags_reg[MODE_COVER_BIT];
    assign mode_norep  = mode_flags_reg[MODE_NOREP_BIT];
    assign mode_onecyc = mode_flags_reg[MODE_ONECYC_BIT];

    assign cnt_ext = CMPW'(command_count_reg);
    assign max_ext = CMPW'(MAX_COMMANDS);
    assign n_wide  = (cnt_ext > max_ext) ? max_ext : cnt_ext;
    assign n_eff   = n_wide[CW-1:0];

    always_comb
    begin
        for (int i = 0; i < MAX_COMMANDS; i++)
        begin
            in_range[i] = (CW'(i) < n_eff);
        end
    end

    assign busy_wide = {{MAX_COMMANDS{1'b0}}, busy_mask};
    assign busy_in   = busy_wide[MAX_COMMANDS-1:0];
    assign last_bit  = {{(MAX_COMMANDS-1){1'b0}}, 1'b1} << last_index_reg;

    assign n_cmp    = (IW+1)'(n_eff);
    assign seq_next = last_valid_reg ? ({1'b0, last_index_reg} + 1'b1) : '0;

    // coverall refill keeps the last pick excluded with no-repeat and n > 1
    assign refill_keep   = mode_norep && (n_eff > CW'(1));
    assign last_in_range = ({1'b0, last_index_reg} < n_cmp);

    assign product = rnd_reg * free_reg;

    // rank not reached falls back to index 0
    assign pick      = scan_rsp.hit ? scan_index : '0;
    assign pick_wide = {{SEL_W{1'b0}}, pick};

    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign req_xfer  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        scan_req.start = (state_reg == S_COUNT_GO) || (state_reg == S_FIND_GO);
        scan_req.find  = (state_reg == S_FIND_GO);
    end

    always_comb
    begin
        state_next          = state_reg;
        command_count_next  = command_count_reg;
        mode_flags_next     = mode_flags_reg;
        last_valid_next     = last_valid_reg;
        last_index_next     = last_index_reg;
        excl_next           = excl_reg;
        free_next           = free_reg;
        nth_next            = nth_reg;
        rnd_next            = rnd_reg;
        rsp_valid_next      = rsp_valid_reg && rsp_stall;
        selected_index_next = selected_index_reg;
        found_next          = found_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COMMAND_COUNT: command_count_next = cfg_data[COUNT_W-1:0];
                REG_MODE_FLAGS:    mode_flags_next    = cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    rnd_next = random_value;
                    if (operation == OP_CLEAR)
                    begin
                        last_valid_next     = 1'b0;
                        last_index_next     = '0;
                        excl_next           = '0;
                        rsp_valid_next      = 1'b1;
                        selected_index_next = '0;
                        found_next          = 1'b0;
                    end
                    else if (n_eff == '0)
                    begin
                        rsp_valid_next      = 1'b1;
                        selected_index_next = '0;
                        found_next          = 1'b0;
                    end
                    else if (mode_seq)
                    begin
                        rsp_valid_next = 1'b1;
                        if (seq_next >= n_cmp && mode_onecyc)
                        begin
                            // one pass done: stop
                            last_valid_next     = 1'b0;
                            last_index_next     = '0;
                            selected_index_next = '0;
                            found_next          = 1'b0;
                        end
                        else if (seq_next >= n_cmp)
                        begin
                            last_valid_next     = 1'b1;
                            last_index_next     = '0;
                            selected_index_next = '0;
                            found_next          = 1'b1;
                        end
                        else
                        begin
                            last_valid_next     = 1'b1;
                            last_index_next     = seq_next[IW-1:0];
                            selected_index_next = pick_wide[SEL_W-1:0] & '0
                                                  | SEL_W'({{SEL_W{1'b0}}, seq_next[IW-1:0]});
                            found_next          = 1'b1;
                        end
                    end
                    else if (!last_valid_reg)
                    begin
                        // no previous pick: mask left as is, all n count as free
                        free_next  = n_eff;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        if (mode_cover)
                            excl_next = excl_reg | last_bit;
                        else
                            excl_next = (busy_in & in_range)
                                        | (mode_norep ? last_bit : '0);
                        state_next = S_COUNT_GO;
                    end
                end
            end

            S_COUNT_GO:
            begin
                state_next = S_COUNT;
            end

            S_COUNT:
            begin
                if (scan_rsp.done)
                begin
                    if (scan_count != '0)
                    begin
                        free_next  = scan_count;
                        state_next = S_MUL;
                    end
                    else if (!mode_cover || mode_onecyc)
                    begin
                        // nothing left; coverall still refills its mask
                        if (mode_cover)
                            excl_next = refill_keep ? last_bit : '0;
                        rsp_valid_next      = 1'b1;
                        selected_index_next = '0;
                        found_next          = 1'b0;
                        state_next          = S_IDLE;
                    end
                    else
                    begin
                        excl_next  = refill_keep ? last_bit : '0;
                        free_next  = n_eff - CW'(refill_keep && last_in_range);
                        state_next = S_MUL;
                    end
                end
            end

            S_MUL:
            begin
                nth_next   = product[RND_W+CW-1:RND_W];
                state_next = S_FIND_GO;
            end

            S_FIND_GO:
            begin
                state_next = S_FIND;
            end

            S_FIND:
            begin
                if (scan_rsp.done)
                begin
                    last_valid_next     = 1'b1;
                    last_index_next     = pick;
                    rsp_valid_next      = 1'b1;
                    selected_index_next = pick_wide[SEL_W-1:0];
                    found_next          = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            command_count_reg  <= COUNT_W'(1);
            mode_flags_reg     <= '0;
            last_valid_reg     <= 1'b0;
            last_index_reg     <= '0;
            excl_reg           <= '0;
            free_reg           <= '0;
            nth_reg            <= '0;
            rnd_reg            <= '0;
            rsp_valid_reg      <= 1'b0;
            selected_index_reg <= '0;
            found_reg          <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            command_count_reg  <= command_count_next;
            mode_flags_reg     <= mode_flags_next;
            last_valid_reg     <= last_valid_next;
            last_index_reg     <= last_index_next;
            excl_reg           <= excl_next;
            free_reg           <= free_next;
            nth_reg            <= nth_next;
            rnd_reg            <= rnd_next;
            rsp_valid_reg      <= rsp_valid_next;
            selected_index_reg <= selected_index_next;
            found_reg          <= found_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign selected_index = selected_index_reg;
    assign found          = found_reg;

endmodule
